[rtl/rtpllj_pkg.sv]
// Shared types and constants of the RTP loss and jitter meter.
`default_nettype none
package rtpllj_pkg;

  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned EXT_W      = 32;
  localparam int unsigned LOST_W     = 33;
  localparam int unsigned ARR_W      = 64;
  localparam int unsigned STS_W      = 32;
  localparam int unsigned OUT_W      = 48;
  localparam int unsigned RATE_W     = 20;
  localparam int unsigned WLEN_W     = 9;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned NS_W       = 30;
  localparam int unsigned PROD_W     = STS_W + NS_W;

  localparam logic [RATE_W-1:0] RATE_RESET = 20'd48000;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd64;
  localparam logic [NS_W-1:0]   NS_PER_SEC = 30'd1000000000;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 4'd1;

  // Work handed from the front to the back
  typedef struct packed {
    logic [SEQ_W-1:0]  ext_first;
    logic [EXT_W-1:0]  ext_last;
    logic [EXT_W-1:0]  expected;
    logic [LOST_W-1:0] lost;
    logic              jit;
    logic [ARR_W-1:0]  adelta;
    logic              neg;
    logic [STS_W-1:0]  mag;
  } job_t;

endpackage
`default_nettype wire

[rtl/rtpllj_fifo.sv]
// Two-entry queue of jobs between the front and the back.
`default_nettype none
module rtpllj_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  rtpllj_pkg::job_t    data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                valid_o,
  output rtpllj_pkg::job_t    data_o
);

  rtpllj_pkg::job_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = entry_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

[rtl/rtpllj_front.sv]
// Front: accepts packets, tracks sequence numbers and prepares timestamp deltas.
`default_nettype none
module rtpllj_front (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  [rtpllj_pkg::SEQ_W-1:0]          seq_number_i,
  input  wire                                   restored_i,
  input  wire  signed [rtpllj_pkg::ARR_W-1:0]   arrival_ns_i,
  input  wire  [rtpllj_pkg::STS_W-1:0]          stream_ts_i,
  input  wire                                   fifo_full_i,
  output logic                                  push_o,
  output rtpllj_pkg::job_t                      job_o
);

  logic                          first_flag_q;
  logic [rtpllj_pkg::SEQ_W-1:0]  first_seq_q, first_seq_d;
  logic [rtpllj_pkg::SEQ_W-1:0]  wrap_q, wrap_d;
  logic [rtpllj_pkg::SEQ_W-1:0]  last_q, last_d;
  logic [rtpllj_pkg::EXT_W-1:0]  proc_q, proc_d;
  logic [rtpllj_pkg::ARR_W-1:0]  prev_arr_q;
  logic [rtpllj_pkg::STS_W-1:0]  prev_sts_q;
  logic [rtpllj_pkg::SEQ_W-1:0]  d_first, d_last;
  logic [rtpllj_pkg::STS_W-1:0]  ds;
  logic [rtpllj_pkg::EXT_W-1:0]  ext_last, expected;
  logic                          adv, accept;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // Classify the sequence number and build the job
  always_comb begin
    d_first     = seq_number_i - first_seq_q;
    d_last      = seq_number_i - last_q;
    first_seq_d = ((first_flag_q || d_first[rtpllj_pkg::SEQ_W-1]) && wrap_q == '0)
                  ? seq_number_i : first_seq_q;
    adv         = !first_flag_q && !d_last[rtpllj_pkg::SEQ_W-1] && d_last != '0;
    if (first_flag_q) begin
      wrap_d = '0;
    end else if (adv && seq_number_i < last_q) begin
      wrap_d = wrap_q + 1'b1;
    end else begin
      wrap_d = wrap_q;
    end
    last_d   = (first_flag_q || adv) ? seq_number_i : last_q;
    proc_d   = proc_q + 1'b1;
    ext_last = {wrap_d, last_d};
    expected = ext_last - {16'd0, first_seq_d} + 1'b1;
    ds       = stream_ts_i - prev_sts_q;

    job_o.ext_first = first_seq_d;
    job_o.ext_last  = ext_last;
    job_o.expected  = expected;
    job_o.lost      = {1'b0, expected} - {1'b0, proc_d};
    job_o.jit       = !first_flag_q && !restored_i;
    job_o.adelta    = arrival_ns_i - prev_arr_q;
    job_o.neg       = ds[rtpllj_pkg::STS_W-1];
    job_o.mag       = ds[rtpllj_pkg::STS_W-1] ? (~ds + 1'b1) : ds;
  end

  // Update tracking state on each transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_flag_q <= 1'b1;
      first_seq_q  <= '0;
      wrap_q       <= '0;
      last_q       <= '0;
      proc_q       <= '0;
      prev_arr_q   <= '1;
      prev_sts_q   <= '0;
    end else if (accept) begin
      first_flag_q <= 1'b0;
      first_seq_q  <= first_seq_d;
      wrap_q       <= wrap_d;
      last_q       <= last_d;
      proc_q       <= proc_d;
      if (!restored_i) begin
        prev_arr_q <= arrival_ns_i;
        prev_sts_q <= stream_ts_i;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/rtpllj_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rtpllj_div #(
  parameter int unsigned N = 64,
  parameter int unsigned D = 20
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  input  wire  [N-1:0] dividend_i,
  input  wire  [D-1:0] divisor_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [N-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic [N-1:0]     quo_q;
  logic [D-1:0]     rem_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [D:0]       trial, diff;
  logic             ge;

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // Trial subtraction of one step
  always_comb begin
    trial = {rem_q, quo_q[N-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[N-2:0], ge};
      rem_q <= ge ? diff[D-1:0] : trial[D-1:0];
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(N);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/rtpllj_back.sv]
// Back: jitter conversion, sliding window statistics and the result register.
`default_nettype none
module rtpllj_back #(
  parameter int unsigned MAX_WINDOW   = 256,
  parameter int unsigned JITTER_WIDTH = 48
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire  [rtpllj_pkg::RATE_W-1:0]         rate_i,
  input  wire  [rtpllj_pkg::WLEN_W-1:0]         wlen_i,
  input  wire                                   win_clear_i,
  input  wire                                   fifo_valid_i,
  input  rtpllj_pkg::job_t                      job_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic [rtpllj_pkg::SEQ_W-1:0]          ext_first_o,
  output logic [rtpllj_pkg::EXT_W-1:0]          ext_last_o,
  output logic [rtpllj_pkg::EXT_W-1:0]          expected_count_o,
  output logic signed [rtpllj_pkg::LOST_W-1:0]  lost_count_o,
  output logic [rtpllj_pkg::OUT_W-1:0]          jitter_mean_o,
  output logic [rtpllj_pkg::OUT_W-1:0]          jitter_max_o,
  output logic [rtpllj_pkg::OUT_W-1:0]          jitter_min_o,
  output logic                                  jitter_updated_o
);

  localparam int unsigned JW     = JITTER_WIDTH;
  localparam int unsigned IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W  = JW + FILL_W;
  localparam int unsigned CMP_W  = (FILL_W > rtpllj_pkg::WLEN_W) ? FILL_W : rtpllj_pkg::WLEN_W;
  localparam int unsigned DVD_W  = (SUM_W > rtpllj_pkg::PROD_W) ? SUM_W : rtpllj_pkg::PROD_W;
  localparam int unsigned DVS_W  = (FILL_W > rtpllj_pkg::RATE_W) ? FILL_W : rtpllj_pkg::RATE_W;
  localparam int unsigned AW     = rtpllj_pkg::ARR_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_QDIV  = 4'd2;
  localparam logic [3:0] S_QWAIT = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_ABS   = 4'd5;
  localparam logic [3:0] S_RDOLD = 4'd6;
  localparam logic [3:0] S_SUB   = 4'd7;
  localparam logic [3:0] S_ADD   = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_MDIV  = 4'd10;
  localparam logic [3:0] S_MWAIT = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]                      state_q;
  rtpllj_pkg::job_t                job_q;
  logic [rtpllj_pkg::PROD_W-1:0]   prod_q;
  logic [AW-1:0]                   diff_q, absv;
  logic [JW-1:0]                   jit_q, mx_q, mn_q;
  logic [JW-1:0]                   ring_mem [MAX_WINDOW];
  logic [JW-1:0]                   rd_q;
  logic [IDX_W-1:0]                rd_addr;
  logic [IDX_W-1:0]                ptr_q;
  logic [FILL_W-1:0]               fill_q, idx_q, len;
  logic [CMP_W-1:0]                wl_ext;
  logic [SUM_W-1:0]                sum_q;
  logic                            pv_q, full;
  logic [rtpllj_pkg::RATE_W-1:0]   rate_eff;
  logic [rtpllj_pkg::OUT_W-1:0]    mean_q, max_q, min_q;
  logic                            div_start, div_busy, div_done;
  logic [DVD_W-1:0]                div_dvd, div_quo;
  logic [DVS_W-1:0]                div_dvs;
  logic [AW-1:0]                   q64;

  // Effective window length and sample rate
  always_comb begin
    wl_ext = CMP_W'(wlen_i);
    if (wl_ext == '0) begin
      len = FILL_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      len = FILL_W'(MAX_WINDOW);
    end else begin
      len = FILL_W'(wl_ext);
    end
    rate_eff = (rate_i == '0) ? rtpllj_pkg::RATE_W'(1) : rate_i;
    full     = fill_q == len;
    q64      = AW'(div_quo);
    absv     = diff_q[AW-1] ? (~diff_q + 1'b1) : diff_q;
  end

  // Share one divider for the ns conversion and the window mean
  always_comb begin
    div_start = (state_q == S_QDIV) || (state_q == S_MDIV);
    if (state_q == S_MDIV) begin
      div_dvd = DVD_W'(sum_q);
      div_dvs = DVS_W'(fill_q);
    end else begin
      div_dvd = DVD_W'(prod_q) + DVD_W'(rate_eff >> 1);
      div_dvs = DVS_W'(rate_eff);
    end
  end

  rtpllj_div #(
    .N (DVD_W),
    .D (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign pop_o   = (state_q == S_IDLE) && fifo_valid_i;
  assign rd_addr = (state_q == S_SCAN) ? idx_q[IDX_W-1:0] : ptr_q;

  // Window memory: write the new sample, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == S_SUB) begin
      ring_mem[ptr_q] <= jit_q;
    end
    rd_q <= ring_mem[rd_addr];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= job_q.mag * rtpllj_pkg::NS_PER_SEC;
    end
    if (state_q == S_DIFF) begin
      diff_q <= job_q.neg ? (job_q.adelta + q64) : (job_q.adelta - q64);
    end
    if (state_q == S_ABS) begin
      jit_q <= (|(absv >> JW)) ? '1 : absv[JW-1:0];
    end
    if (state_q == S_ADD) begin
      mx_q <= '0;
      mn_q <= '1;
    end else if (state_q == S_SCAN && pv_q) begin
      if (rd_q > mx_q) mx_q <= rd_q;
      if (rd_q < mn_q) mn_q <= rd_q;
    end
  end

  // Sequencer, window bookkeeping and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      pv_q        <= 1'b0;
      mean_q      <= '0;
      max_q       <= '0;
      min_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && state_q != S_OUT) begin
        out_valid_o <= 1'b0;
      end
      if (win_clear_i) begin
        ptr_q  <= '0;
        fill_q <= '0;
        sum_q  <= '0;
      end
      case (state_q)
        S_IDLE: begin
          if (fifo_valid_i) begin
            state_q <= job_i.jit ? S_MUL : S_OUT;
          end
        end
        S_MUL:   state_q <= S_QDIV;
        S_QDIV:  state_q <= S_QWAIT;
        S_QWAIT: begin
          if (div_done) state_q <= S_DIFF;
        end
        S_DIFF:  state_q <= S_ABS;
        S_ABS:   state_q <= S_RDOLD;
        S_RDOLD: state_q <= S_SUB;
        S_SUB: begin
          // drop the oldest sample once the window is full
          if (full) begin
            sum_q <= sum_q - SUM_W'(rd_q);
          end else begin
            fill_q <= fill_q + 1'b1;
          end
          ptr_q   <= (FILL_W'(ptr_q) + 1'b1 == len) ? '0 : ptr_q + 1'b1;
          state_q <= S_ADD;
        end
        S_ADD: begin
          sum_q   <= sum_q + SUM_W'(jit_q);
          idx_q   <= '0;
          pv_q    <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (idx_q != fill_q) begin
            idx_q <= idx_q + 1'b1;
            pv_q  <= 1'b1;
          end else begin
            pv_q <= 1'b0;
            if (!pv_q) state_q <= S_MDIV;
          end
        end
        S_MDIV:  state_q <= S_MWAIT;
        S_MWAIT: begin
          if (div_done) begin
            mean_q  <= div_quo[rtpllj_pkg::OUT_W-1:0];
            max_q   <= rtpllj_pkg::OUT_W'(mx_q);
            min_q   <= rtpllj_pkg::OUT_W'(mn_q);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Load the result fields
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_o || out_ready_i)) begin
      ext_first_o      <= job_q.ext_first;
      ext_last_o       <= job_q.ext_last;
      expected_count_o <= job_q.expected;
      lost_count_o     <= $signed(job_q.lost);
      jitter_mean_o    <= mean_q;
      jitter_max_o     <= max_q;
      jitter_min_o     <= min_q;
      jitter_updated_o <= job_q.jit;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(MAX_WINDOW))
    else $error("window fill beyond its maximum");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_busy)
    else $error("divider busy while the back is idle");

  a_fill_after_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUB && !win_clear_i) |=> (fill_q != '0))
    else $error("window empty after a sample was added");

endmodule
`default_nettype wire

[rtl/rtp_link_loss_jitter_meter_unit.sv]
// Top level of the RTP loss and jitter meter: configuration registers and channels.
`default_nettype none
// Each accepted packet yields one result with sequence, loss and jitter window
// statistics. The front takes one packet per cycle into a two-entry queue while
// the queue is not full; the back handles one packet at a time. A recovered or
// first packet skips the jitter steps of the back. A packet that adds a jitter
// sample uses the shared serial divider twice (62 bits wide at the default
// parameters, one quotient bit per cycle), once to turn stream samples into ns
// and once for the window mean, and scans the current window fill one memory
// read per cycle for maximum and minimum. A window length write clears the
// window.
module rtp_link_loss_jitter_meter_unit #(
  parameter int unsigned MAX_WINDOW   = 256,
  parameter int unsigned JITTER_WIDTH = 48
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire  [rtpllj_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire  [rtpllj_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  wire                                       in_valid_i,
  output logic                                      in_ready_o,
  input  wire  [rtpllj_pkg::SEQ_W-1:0]              seq_number_i,
  input  wire                                       restored_i,
  input  wire  signed [rtpllj_pkg::ARR_W-1:0]       arrival_ns_i,
  input  wire  [rtpllj_pkg::STS_W-1:0]              stream_ts_i,
  output logic                                      out_valid_o,
  input  wire                                       out_ready_i,
  output logic [rtpllj_pkg::SEQ_W-1:0]              ext_first_o,
  output logic [rtpllj_pkg::EXT_W-1:0]              ext_last_o,
  output logic [rtpllj_pkg::EXT_W-1:0]              expected_count_o,
  output logic signed [rtpllj_pkg::LOST_W-1:0]      lost_count_o,
  output logic [rtpllj_pkg::OUT_W-1:0]              jitter_mean_o,
  output logic [rtpllj_pkg::OUT_W-1:0]              jitter_max_o,
  output logic [rtpllj_pkg::OUT_W-1:0]              jitter_min_o,
  output logic                                      jitter_updated_o
);

  logic [rtpllj_pkg::RATE_W-1:0] rate_q;
  logic [rtpllj_pkg::WLEN_W-1:0] wlen_q;
  logic                          cfg_acc, win_clear;
  logic                          fifo_full, fifo_valid, push, pop;
  rtpllj_pkg::job_t              job_in, job_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign win_clear   = cfg_acc && (cfg_index_i == rtpllj_pkg::CFG_WINDOW_LEN);

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= rtpllj_pkg::RATE_RESET;
      wlen_q <= rtpllj_pkg::WLEN_RESET;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        rtpllj_pkg::CFG_SAMPLE_RATE: rate_q <= cfg_data_i;
        rtpllj_pkg::CFG_WINDOW_LEN:  wlen_q <= cfg_data_i[rtpllj_pkg::WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  rtpllj_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .seq_number_i (seq_number_i),
    .restored_i   (restored_i),
    .arrival_ns_i (arrival_ns_i),
    .stream_ts_i  (stream_ts_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .job_o        (job_in)
  );

  rtpllj_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (job_out)
  );

  rtpllj_back #(
    .MAX_WINDOW   (MAX_WINDOW),
    .JITTER_WIDTH (JITTER_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rate_i           (rate_q),
    .wlen_i           (wlen_q),
    .win_clear_i      (win_clear),
    .fifo_valid_i     (fifo_valid),
    .job_i            (job_out),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ext_first_o      (ext_first_o),
    .ext_last_o       (ext_last_o),
    .expected_count_o (expected_count_o),
    .lost_count_o     (lost_count_o),
    .jitter_mean_o    (jitter_mean_o),
    .jitter_max_o     (jitter_max_o),
    .jitter_min_o     (jitter_min_o),
    .jitter_updated_o (jitter_updated_o)
  );

endmodule
`default_nettype wire
